// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the mixer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mwm_pkg.sv =====
// ----------------------------------------------------------------------------
// Mecanum wheel mixer package
// Field widths, lane count and reset constants shared by the mixer RTL.
// ----------------------------------------------------------------------------
package mwm_pkg;

  localparam int FIELD_W       = 16;  // command and drive fields
  localparam int MIX_W         = 18;  // signed sum of three fields
  localparam int MAG_W         = 17;  // magnitude of a mix
  localparam int GAIN_W        = 15;  // gain register
  localparam int QUO_W         = 15;  // quotient never exceeds the gain
  localparam int LANES         = 4;
  localparam int FRAC_BITS_DEF = 14;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd15565;  // 0.95

  // Wheel lanes
  localparam int LANE_LF = 0;
  localparam int LANE_RF = 1;
  localparam int LANE_LR = 2;
  localparam int LANE_RR = 3;

endpackage

// ===== rtl/core/mwm_channels.sv =====
// ----------------------------------------------------------------------------
// Mecanum wheel mixer channels
// Valid/ready interfaces for the command request and the drive request.
// ----------------------------------------------------------------------------
interface mwm_cmd_if;
  import mwm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] strafe;
  logic signed [FIELD_W-1:0] forward;
  logic signed [FIELD_W-1:0] turn;

  modport source (output valid, output strafe, output forward, output turn, input ready);
  modport sink   (input valid, input strafe, input forward, input turn, output ready);
endinterface

interface mwm_drive_if;
  import mwm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] drive_left_front;
  logic signed [FIELD_W-1:0] drive_right_front;
  logic signed [FIELD_W-1:0] drive_left_rear;
  logic signed [FIELD_W-1:0] drive_right_rear;

  modport source (output valid, output drive_left_front, output drive_right_front,
                  output drive_left_rear, output drive_right_rear, input ready);
  modport sink   (input valid, input drive_left_front, input drive_right_front,
                  input drive_left_rear, input drive_right_rear, output ready);
endinterface

// ===== rtl/core/mwm_divider.sv =====
// ----------------------------------------------------------------------------
// Mixer divider pipeline
// Four-lane restoring divider sharing one divisor, one quotient bit a stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mwm_divider #(
  parameter int NUM_W = mwm_pkg::MAG_W + mwm_pkg::GAIN_W,
  parameter int DEN_W = mwm_pkg::MAG_W
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [mwm_pkg::LANES-1:0][NUM_W-1:0]        in_num,
  input  logic [mwm_pkg::LANES-1:0]                   in_neg,
  input  logic [DEN_W-1:0]                            in_den,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [mwm_pkg::LANES-1:0][mwm_pkg::QUO_W-1:0] out_quo,
  output logic [mwm_pkg::LANES-1:0]                   out_neg
);
  import mwm_pkg::*;

  localparam int STAGES = QUO_W;
  localparam int CMP_W  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] v_in;
  logic [STAGES:0]   load;

  logic [LANES-1:0][NUM_W-1:0] rem      [STAGES];
  logic [LANES-1:0][QUO_W-1:0] quo      [STAGES];
  logic [LANES-1:0]            neg      [STAGES];
  logic [DEN_W-1:0]            den      [STAGES];

  logic [LANES-1:0][NUM_W-1:0] rem_in   [STAGES];
  logic [LANES-1:0][QUO_W-1:0] quo_in   [STAGES];
  logic [LANES-1:0]            neg_in   [STAGES];
  logic [DEN_W-1:0]            den_in   [STAGES];
  logic [LANES-1:0][NUM_W-1:0] rem_next [STAGES];
  logic [LANES-1:0][QUO_W-1:0] quo_next [STAGES];

  // A stage loads when empty or when its contents move on.
  always_comb begin
    load[STAGES] = out_ready;
    for (int s = STAGES - 1; s >= 0; s--) begin
      load[s] = !v[s] || load[s+1];
    end
  end

  assign v_in = {v[STAGES-2:0], in_valid};

  always_comb begin
    rem_in[0] = in_num;
    quo_in[0] = '0;
    neg_in[0] = in_neg;
    den_in[0] = in_den;
    for (int s = 1; s < STAGES; s++) begin
      rem_in[s] = rem[s-1];
      quo_in[s] = quo[s-1];
      neg_in[s] = neg[s-1];
      den_in[s] = den[s-1];
    end
  end

  // Stage s resolves quotient bit QUO_W-1-s for every lane.
  always_comb begin
    logic [CMP_W-1:0] trial;
    for (int s = 0; s < STAGES; s++) begin
      trial = CMP_W'(den_in[s]) << (QUO_W - 1 - s);
      for (int l = 0; l < LANES; l++) begin
        rem_next[s][l] = rem_in[s][l];
        quo_next[s][l] = quo_in[s][l];
        if (CMP_W'(rem_in[s][l]) >= trial) begin
          rem_next[s][l] = rem_in[s][l] - trial[NUM_W-1:0];
          quo_next[s][l][QUO_W-1-s] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < STAGES; s++) begin
        if (load[s]) begin
          v[s] <= v_in[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) begin
      if (load[s]) begin
        rem[s] <= rem_next[s];
        quo[s] <= quo_next[s];
        neg[s] <= neg_in[s];
        den[s] <= den_in[s];
      end
    end
  end

  assign in_ready  = load[0];
  assign out_valid = v[STAGES-1];
  assign out_quo   = quo[STAGES-1];
  assign out_neg   = neg[STAGES-1];

  for (genvar l = 0; l < LANES; l++) begin : g_chk
    `ASSERT_IMPLIES(a_rem_below_den, clk, rst, v[STAGES-1],
      CMP_W'(rem[STAGES-1][l]) < CMP_W'(den[STAGES-1]), "remainder not below divisor")
  end

endmodule

// ===== rtl/core/mecanum_wheel_mixer.sv =====
// ----------------------------------------------------------------------------
// Mecanum wheel mixer
// Pipeline: 20 register stages.
// Throughput: one request per cycle while the drive sink is ready, set by the
//   15-stage divider pipeline.
// Reset: clears every valid bit and loads max_gain with 0.95 (15565).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mecanum_wheel_mixer #(
  parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        gain_wr_en,
  input  logic [mwm_pkg::GAIN_W-1:0]  gain_wr_data,
  mwm_cmd_if.sink                     cmd,
  mwm_drive_if.source                 drive
);
  import mwm_pkg::*;

  // Divisor wide enough for both the largest magnitude and 1.0.
  localparam int D_W    = (MAG_W > FRAC_BITS + 1) ? MAG_W : FRAC_BITS + 1;
  localparam int PROD_W = MAG_W + GAIN_W;
  localparam logic [D_W-1:0] ONE_D = D_W'(1) << FRAC_BITS;

  // --------------------------------------------------------------------------
  // Gain register and its ceiling at 1.0
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0] max_gain;
  logic [GAIN_W-1:0] g_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gain <= GAIN_RESET;
    end else if (gain_wr_en) begin
      max_gain <= gain_wr_data;
    end
  end

  // Clamp to 1.0; when 1.0 is beyond the register range the clamp never acts.
  assign g_eff = (D_W'(max_gain) > ONE_D) ? ONE_D[GAIN_W-1:0] : max_gain;

  // --------------------------------------------------------------------------
  // Pipeline control. Each stage loads when empty or when it drains; the
  // ready chain runs back from the output register, so a stall holds every
  // stage in place and nothing is dropped or repeated.
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4, ov;
  logic load1, load2, load3, load4, load_o;
  logic div_in_ready, div_out_valid;

  logic [LANES-1:0][QUO_W-1:0] div_quo;
  logic [LANES-1:0]            div_neg;

  assign load_o    = !ov || drive.ready;
  assign load4     = !v4 || div_in_ready;
  assign load3     = !v3 || load4;
  assign load2     = !v2 || load3;
  assign load1     = !v1 || load2;
  assign cmd.ready = load1;
  assign drive.valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (load1) begin
        v1 <= cmd.valid;
      end
      if (load2) begin
        v2 <= v1;
      end
      if (load3) begin
        v3 <= v2;
      end
      if (load4) begin
        v4 <= v3;
      end
      if (load_o) begin
        ov <= div_out_valid;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: wheel mixes, exact in MIX_W bits
  // --------------------------------------------------------------------------
  logic signed [MIX_W-1:0] x_ext, y_ext, r_ext;
  logic signed [MIX_W-1:0] s1_mix [LANES];

  assign x_ext = MIX_W'(cmd.strafe);
  assign y_ext = MIX_W'(cmd.forward);
  assign r_ext = MIX_W'(cmd.turn);

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_mix[LANE_LF] <= y_ext + x_ext + r_ext;
      s1_mix[LANE_RF] <= y_ext - x_ext - r_ext;
      s1_mix[LANE_LR] <= y_ext - x_ext + r_ext;
      s1_mix[LANE_RR] <= y_ext + x_ext - r_ext;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: split each mix into sign and magnitude
  // --------------------------------------------------------------------------
  logic signed [MIX_W-1:0] abs_c [LANES];
  logic [MAG_W-1:0]        s2_mag [LANES];
  logic [LANES-1:0]        s2_neg;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      abs_c[l] = s1_mix[l][MIX_W-1] ? -s1_mix[l] : s1_mix[l];
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      for (int l = 0; l < LANES; l++) begin
        s2_mag[l] <= abs_c[l][MAG_W-1:0];
        s2_neg[l] <= s1_mix[l][MIX_W-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: first level of the largest-magnitude tree (front pair, rear pair)
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0] s3_pmax_f, s3_pmax_r;
  logic [MAG_W-1:0] s3_mag [LANES];
  logic [LANES-1:0] s3_neg;

  always_ff @(posedge clk) begin
    if (load3) begin
      s3_pmax_f <= (s2_mag[LANE_LF] > s2_mag[LANE_RF]) ? s2_mag[LANE_LF] : s2_mag[LANE_RF];
      s3_pmax_r <= (s2_mag[LANE_LR] > s2_mag[LANE_RR]) ? s2_mag[LANE_LR] : s2_mag[LANE_RR];
      s3_mag    <= s2_mag;
      s3_neg    <= s2_neg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: divisor = max(1.0, largest magnitude); scale each magnitude by
  // the gain so the divider does a single truncating division.
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0]             pmax;
  logic [D_W-1:0]               s4_den;
  logic [LANES-1:0][PROD_W-1:0] s4_prod;
  logic [LANES-1:0]             s4_neg;

  assign pmax = (s3_pmax_f > s3_pmax_r) ? s3_pmax_f : s3_pmax_r;

  always_ff @(posedge clk) begin
    if (load4) begin
      s4_den <= (D_W'(pmax) > ONE_D) ? D_W'(pmax) : ONE_D;
      for (int l = 0; l < LANES; l++) begin
        s4_prod[l] <= PROD_W'(s3_mag[l]) * PROD_W'(g_eff);
      end
      s4_neg <= s3_neg;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 5 to 19: magnitude division, one quotient bit per stage
  // --------------------------------------------------------------------------
  mwm_divider #(
    .NUM_W (PROD_W),
    .DEN_W (D_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_ready  (div_in_ready),
    .in_num    (s4_prod),
    .in_neg    (s4_neg),
    .in_den    (s4_den),
    .out_valid (div_out_valid),
    .out_ready (load_o),
    .out_quo   (div_quo),
    .out_neg   (div_neg)
  );

  // --------------------------------------------------------------------------
  // Stage 20: restore the sign and hold the drive request for the sink.
  // Truncating the magnitude then negating gives rounding toward zero.
  // --------------------------------------------------------------------------
  logic [FIELD_W-1:0] q_ext [LANES];
  logic [FIELD_W-1:0] drv_c [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      q_ext[l] = FIELD_W'(div_quo[l]);
      drv_c[l] = div_neg[l] ? -q_ext[l] : q_ext[l];
    end
  end

  always_ff @(posedge clk) begin
    if (load_o) begin
      drive.drive_left_front  <= drv_c[LANE_LF];
      drive.drive_right_front <= drv_c[LANE_RF];
      drive.drive_left_rear   <= drv_c[LANE_LR];
      drive.drive_right_rear  <= drv_c[LANE_RR];
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `ASSERT_NEXT(a_accept_enters, clk, rst, cmd.valid && cmd.ready, v1,
    "accepted request did not enter the first stage")
  `ASSERT_IMPLIES(a_ready_when_drained, clk, rst, !ov, cmd.ready,
    "not ready although the output register is empty")
  `ASSERT_IMPLIES(a_quo_bound, clk, rst, div_out_valid,
    (D_W'(div_quo[LANE_LF]) <= ONE_D) && (D_W'(div_quo[LANE_RF]) <= ONE_D) &&
    (D_W'(div_quo[LANE_LR]) <= ONE_D) && (D_W'(div_quo[LANE_RR]) <= ONE_D),
    "drive magnitude above 1.0")

endmodule

// ===== sim/mecanum_wheel_mixer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum wheel mixer testbench
// Drives command requests into the mixer and checks every drive request
// against a local fixed-point predictor of the four-wheel mix, the
// normalisation and the gain scaling. The run passes through several gain
// settings and sender/receiver stall profiles, starting with a directed set
// of corner commands and then a long random stream.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_tb;
  import mwm_pkg::*;

  localparam longint FX_ONE    = longint'(1) << FRAC_BITS_DEF;
  localparam int     PHASES    = 6;
  localparam int     PHASE_LEN = 175;
  localparam int     DRAIN_MAX = 20000;  // cycles allowed for the pipe to empty
  localparam int     SETTLE    = 40;     // settling wait before the final check

  typedef struct packed {
    logic signed [FIELD_W-1:0] strafe;
    logic signed [FIELD_W-1:0] forward;
    logic signed [FIELD_W-1:0] turn;
  } command_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] left_front;
    logic signed [FIELD_W-1:0] right_front;
    logic signed [FIELD_W-1:0] left_rear;
    logic signed [FIELD_W-1:0] right_rear;
  } drive_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the gain register, predicts the drive
  // request for every accepted command and checks results in order.
  // --------------------------------------------------------------------------
  class drive_scoreboard;
    drive_t             pending_drives[$];
    logic [GAIN_W-1:0]  gain;
    int                 errors;

    function new();
      gain   = GAIN_RESET;
      errors = 0;
    endfunction

    function void set_gain(logic [GAIN_W-1:0] value);
      gain = value;
    endfunction

    function int outstanding();
      return pending_drives.size();
    endfunction

    // Print one line per mismatch; quieten after the first hundred but keep counting.
    task report(string msg);
      if (errors < 100)
        $display("%0t ns  mismatch: %s", $time, msg);
      errors++;
    endtask

    // Mix, normalise by max(1.0, largest |mix|), scale by the clamped gain.
    function drive_t mix_command(command_t c);
      longint mix[LANES];
      longint divisor;
      longint g;
      longint v;
      logic signed [FIELD_W-1:0] lane_out[LANES];
      drive_t d;
      mix[LANE_LF] = longint'(c.forward) + longint'(c.strafe) + longint'(c.turn);
      mix[LANE_RF] = longint'(c.forward) - longint'(c.strafe) - longint'(c.turn);
      mix[LANE_LR] = longint'(c.forward) - longint'(c.strafe) + longint'(c.turn);
      mix[LANE_RR] = longint'(c.forward) + longint'(c.strafe) - longint'(c.turn);
      divisor = FX_ONE;
      foreach (mix[i]) begin
        if (mix[i] > divisor) divisor = mix[i];
        if (-mix[i] > divisor) divisor = -mix[i];
      end
      g = longint'(gain);
      if (g > FX_ONE) g = FX_ONE;
      foreach (mix[i]) begin
        v = (mix[i] * g) / divisor;  // truncates toward zero
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        lane_out[i] = v[FIELD_W-1:0];
      end
      d.left_front  = lane_out[LANE_LF];
      d.right_front = lane_out[LANE_RF];
      d.left_rear   = lane_out[LANE_LR];
      d.right_rear  = lane_out[LANE_RR];
      return d;
    endfunction

    function void note_command(command_t c);
      pending_drives.push_back(mix_command(c));
    endfunction

    task compare_lane(string lane, logic signed [FIELD_W-1:0] got,
                      logic signed [FIELD_W-1:0] want);
      if (got !== want)
        report($sformatf("%s got %0d, want %0d", lane, got, want));
    endtask

    task check_drive(drive_t got);
      drive_t want;
      if (pending_drives.size() == 0) begin
        report("drive request with no command outstanding");
        return;
      end
      want = pending_drives.pop_front();
      compare_lane("left_front", got.left_front, want.left_front);
      compare_lane("right_front", got.right_front, want.right_front);
      compare_lane("left_rear", got.left_rear, want.left_rear);
      compare_lane("right_rear", got.right_rear, want.right_rear);
    endtask
  endclass

  logic clk;
  logic rst;
  logic gain_wr_en;
  logic [GAIN_W-1:0] gain_wr_data;

  mwm_cmd_if   cmd_ch ();
  mwm_drive_if drive_ch ();

  mecanum_wheel_mixer dut (
    .clk          (clk),
    .rst          (rst),
    .gain_wr_en   (gain_wr_en),
    .gain_wr_data (gain_wr_data),
    .cmd          (cmd_ch),
    .drive        (drive_ch)
  );

  drive_scoreboard sb = new();

  // Stall rates, in cycles per hundred, for the command sender and the
  // drive receiver; the main sequence changes them between phases.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("mecanum_wheel_mixer_tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: redraw ready every falling edge, so stalls land on any cycle of
  // the pipeline.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      drive_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitors: sample both handshakes at the rising edge. A command is noted
  // with the gain in force when it is taken; the gain only changes while the
  // block is empty, so that is the gain the block applies.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready)
      sb.note_command('{strafe: cmd_ch.strafe, forward: cmd_ch.forward, turn: cmd_ch.turn});
  end

  always @(posedge clk) begin
    if (!rst && drive_ch.valid && drive_ch.ready)
      sb.check_drive('{left_front:  drive_ch.drive_left_front,
                       right_front: drive_ch.drive_right_front,
                       left_rear:   drive_ch.drive_left_rear,
                       right_rear:  drive_ch.drive_right_rear});
  end

  // --------------------------------------------------------------------------
  // Drivers. Each task is entered just after a falling edge and returns just
  // after a falling edge.
  // --------------------------------------------------------------------------

  // Offer one command request, holding it until the mixer takes it. Drop
  // valid for a random number of cycles first, as the sender stall rate asks.
  // Valid is left high on return so back-to-back requests need no re-raise.
  task automatic push_command(input command_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.strafe  <= c.strafe;
    cmd_ch.forward <= c.forward;
    cmd_ch.turn    <= c.turn;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  // Write the gain register; only called while nothing is in flight.
  task automatic write_gain(input logic [GAIN_W-1:0] value);
    gain_wr_en   <= 1'b1;
    gain_wr_data <= value;
    @(posedge clk);
    sb.set_gain(value);
    @(negedge clk);
    gain_wr_en <= 1'b0;
  endtask

  // Hold off until every predicted drive request has come back. Every
  // command yields exactly one drive, so an empty queue means an empty pipe.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [FIELD_W-1:0] corner_value();
    case ($urandom_range(6))
      0:       return -16'sd32768;
      1:       return -16'sd16384;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      5:       return 16'sd16384;
      default: return 16'sd32767;
    endcase
  endfunction

  // Random command. Four in ten keep every axis within +-1.0, some use the full
  // 16-bit range so the normalisation bites, some are tiny so truncation
  // dominates, and the rest are corners or a single active axis.
  function automatic command_t random_command();
    command_t c;
    int kind;
    int axis;
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2, 3: begin
        c.strafe  = FIELD_W'(int'($urandom_range(32768)) - 16384);
        c.forward = FIELD_W'(int'($urandom_range(32768)) - 16384);
        c.turn    = FIELD_W'(int'($urandom_range(32768)) - 16384);
      end
      4, 5: begin
        c.strafe  = FIELD_W'($urandom());
        c.forward = FIELD_W'($urandom());
        c.turn    = FIELD_W'($urandom());
      end
      6: begin
        c.strafe  = FIELD_W'(int'($urandom_range(128)) - 64);
        c.forward = FIELD_W'(int'($urandom_range(128)) - 64);
        c.turn    = FIELD_W'(int'($urandom_range(128)) - 64);
      end
      7: begin
        c.strafe  = corner_value();
        c.forward = corner_value();
        c.turn    = corner_value();
      end
      default: begin
        c = '0;
        axis = $urandom_range(2);
        case (axis)
          0:       c.strafe  = FIELD_W'($urandom());
          1:       c.forward = FIELD_W'($urandom());
          default: c.turn    = FIELD_W'($urandom());
        endcase
      end
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  command_t          corner_cmds[$];
  logic [GAIN_W-1:0] phase_gain[PHASES];

  initial begin
    int waited;

    // Every input known from time zero; hold reset, then release it on a falling edge.
    rst            = 1'b1;
    gain_wr_en     = 1'b0;
    gain_wr_data   = '0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.strafe  = '0;
    cmd_ch.forward = '0;
    cmd_ch.turn    = '0;
    drive_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners under the reset gain (0.95): zero, unit commands on
    // each axis, full-scale inputs well beyond 1.0 that force normalisation,
    // mixes landing exactly on and just past 1.0, and tiny values.
    corner_cmds = '{
      '{strafe: 16'sd0,      forward: 16'sd0,      turn: 16'sd0},
      '{strafe: 16'sd16384,  forward: 16'sd0,      turn: 16'sd0},
      '{strafe: 16'sd0,      forward: 16'sd16384,  turn: 16'sd0},
      '{strafe: 16'sd0,      forward: 16'sd0,      turn: 16'sd16384},
      '{strafe: -16'sd16384, forward: 16'sd0,      turn: 16'sd0},
      '{strafe: 16'sd0,      forward: -16'sd16384, turn: 16'sd0},
      '{strafe: 16'sd0,      forward: 16'sd0,      turn: -16'sd16384},
      '{strafe: 16'sd32767,  forward: 16'sd32767,  turn: 16'sd32767},
      '{strafe: -16'sd32768, forward: -16'sd32768, turn: -16'sd32768},
      '{strafe: 16'sd32767,  forward: -16'sd32768, turn: 16'sd32767},
      '{strafe: -16'sd32768, forward: 16'sd32767,  turn: -16'sd32768},
      '{strafe: 16'sd16384,  forward: 16'sd16384,  turn: 16'sd16384},
      '{strafe: 16'sd8192,   forward: 16'sd4096,   turn: 16'sd2048},
      '{strafe: -16'sd1,     forward: -16'sd1,     turn: -16'sd1},
      '{strafe: 16'sd1,      forward: 16'sd1,      turn: 16'sd1},
      '{strafe: 16'sd1,      forward: 16'sd0,      turn: 16'sd0},
      '{strafe: 16'sd32767,  forward: 16'sd0,      turn: 16'sd0},
      '{strafe: -16'sd32768, forward: 16'sd0,      turn: 16'sd0},
      '{strafe: 16'sd0,      forward: 16'sd32767,  turn: -16'sd32768},
      '{strafe: 16'sd100,    forward: -16'sd200,   turn: 16'sd300},
      '{strafe: 16'sd16383,  forward: 16'sd1,      turn: 16'sd0},
      '{strafe: 16'sd16384,  forward: 16'sd1,      turn: 16'sd0}
    };
    tx_idle_pct = 6;
    rx_idle_pct = 66;
    foreach (corner_cmds[i]) push_command(corner_cmds[i]);
    drain();

    // Random phases: full gain, a gain above 1.0 that must saturate, zero
    // gain, a random gain, the smallest non-zero gain and just under 1.0.
    phase_gain[0] = 15'd16384;
    phase_gain[1] = 15'd32767;
    phase_gain[2] = 15'd0;
    phase_gain[3] = GAIN_W'($urandom_range(32767));
    phase_gain[4] = 15'd1;
    phase_gain[5] = 15'd16383;

    for (int p = 0; p < PHASES; p++) begin
      // Stall profile: receiver-heavy, then sender-heavy, then none.
      case (p / 2)
        0: begin tx_idle_pct = 6;  rx_idle_pct = 66; end
        1: begin tx_idle_pct = 66; rx_idle_pct = 6;  end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      write_gain(phase_gain[p]);
      repeat (PHASE_LEN) push_command(random_command());
      drain();
    end

    // Let any stray drive request surface before the final verdict.
    waited = 0;
    while (sb.outstanding() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d drive requests never arrived", sb.outstanding()));

    if (sb.errors == 0) begin
      $display("mecanum_wheel_mixer_tb: PASS");
    end else begin
      $display("mecanum_wheel_mixer_tb: FAIL");
    end
    $finish;
  end

endmodule
